>>> hw/rtl/fdfp_pkg.sv
// ----------------------------------------------------------------------------
// fdfp_pkg
// Shared constants and types of the framed decimal field parser: byte codes,
// default sizes and the control word from the frame logic to the field decoder.
// ----------------------------------------------------------------------------
package fdfp_pkg;

    // framing and separator bytes
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_SEP   = 8'h20;

    // bytes the field decoder looks at
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // default sizes
    localparam int NUM_FIELDS_DEF = 7;
    localparam int VALUE_BITS_DEF = 16;

    // fixed result layout
    localparam int OUT_VALUES = 7;
    localparam int FOUND_BITS = 3;
    localparam int BYTE_BITS  = 8;

    // control word from frame logic to field decoder
    typedef struct packed {
        logic clear;   // start a new field
        logic feed;    // apply the byte to the current field
    } fdfp_dec_ctl_t;

endpackage

>>> hw/rtl/fdfp_field_decoder.sv
// ----------------------------------------------------------------------------
// fdfp_field_decoder
// Per-field decimal decoder: skips leading whitespace, takes an optional
// sign, accumulates digits with saturation and presents the signed value.
// ----------------------------------------------------------------------------
module fdfp_field_decoder
    import fdfp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fdfp_dec_ctl_t                ctl,
    input  logic [BYTE_BITS-1:0]         rx_byte,
    output logic signed [VALUE_BITS-1:0] value
);

    localparam int ACC_W = VALUE_BITS + 4;
    localparam logic [ACC_W-1:0] MAG_LIMIT = ACC_W'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;

    logic                    is_digit;
    logic                    is_space;
    logic [ACC_W-1:0]        acc_times_ten;
    logic [ACC_W-1:0]        acc_sat;

    // byte classes
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte >= CH_TAB) && (rx_byte <= CH_CR);

    // magnitude times ten plus digit, saturated at the negative limit
    assign acc_times_ten = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1)
                         + ACC_W'(rx_byte - CH_ZERO);
    assign acc_sat = (acc_times_ten > MAG_LIMIT) ? MAG_LIMIT : acc_times_ten;

    // next field state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (ctl.clear)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else if (ctl.feed)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (rx_byte == CH_PLUS || rx_byte == CH_MINUS)
                    begin
                        neg_next   = (rx_byte == CH_MINUS);
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        phase_next = PH_DIGITS;
                        acc_next   = acc_sat[VALUE_BITS-1:0];
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_sat[VALUE_BITS-1:0];
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // field state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // signed value, positive side limited to the largest positive number
    always_comb
    begin
        if (neg_reg)
        begin
            value = signed'(VALUE_BITS'(~acc_reg + 1'b1));
        end
        else if (acc_reg[VALUE_BITS-1])
        begin
            value = signed'(POS_MAX);
        end
        else
        begin
            value = signed'(acc_reg);
        end
    end

endmodule

>>> hw/rtl/framed_decimal_field_parser.sv
// ----------------------------------------------------------------------------
// framed_decimal_field_parser
// Parses STX/ETX framed ASCII text into up to seven signed decimal fields.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one received byte per word in s_tdata, the source link
//   (0 wired serial, 1 wireless) in s_tuser. STX opens a frame and sets all
//   fields to -1, spaces separate fields, ETX emits one result word.
//   m_* channel: one word per ETX carrying the seven field values, the
//   number of fields found and, in m_tuser, the link that sent the ETX.
//   Bytes after ETX keep extending the same frame until the next STX.
// Timing:
//   a byte is registered on acceptance and applied from the input register;
//   an applied ETX loads the result register, which drives m_tvalid. One
//   byte per cycle is taken unless an ETX waits for the result register; the
//   update is one multiply by ten and add from input to field registers.
// Reset:
//   rst_n clears the frame state; the first non-ETX byte before any STX is dropped.
// Stall:
//   while a result waits on m_tready, non-ETX bytes keep flowing; a second
//   ETX holds in the input register and s_tready drops until the result
//   register frees up.
// ----------------------------------------------------------------------------
module framed_decimal_field_parser
    import fdfp_pkg::*;
#(
    parameter int NUM_FIELDS = NUM_FIELDS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int OUT_W     = OUT_VALUES * VALUE_BITS + FOUND_BITS,
    localparam int TDATA_W   = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] from_wireless
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // value_0 .. value_6, fields_found, zero fill
    output logic                 m_tuser    // [0] end_source
);

    localparam int IDX_W = $clog2(NUM_FIELDS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FIELDS);

    // input register
    logic                    in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]    in_byte_reg;
    logic                    in_src_reg;

    // frame state
    logic                    skip_reg, skip_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [VALUE_BITS-1:0]   committed_reg  [NUM_FIELDS];
    logic [VALUE_BITS-1:0]   committed_next [NUM_FIELDS];

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   out_value_reg  [OUT_VALUES];
    logic [VALUE_BITS-1:0]   out_value_next [OUT_VALUES];
    logic [FOUND_BITS-1:0]   out_found_reg;
    logic [FOUND_BITS-1:0]   out_found_next;
    logic                    out_src_reg;

    logic                    is_stx, is_etx, is_sep;
    logic                    out_free, proc_go, room, do_commit, do_feed;
    logic [IDX_W:0]          found_full;
    logic signed [VALUE_BITS-1:0] cur_value;
    fdfp_dec_ctl_t           dec_ctl;
    logic [OUT_W-1:0]        payload;

    // byte decode and handshake
    assign is_stx   = (in_byte_reg == CH_STX);
    assign is_etx   = (in_byte_reg == CH_ETX);
    assign is_sep   = (in_byte_reg == CH_SEP);
    assign out_free = !out_valid_reg || m_tready;
    assign proc_go  = in_valid_reg && (!is_etx || out_free);
    assign s_tready = !in_valid_reg || proc_go;
    assign room     = (idx_reg < IDX_LAST);

    assign do_commit = proc_go && !is_stx && !is_etx && !skip_reg && room && is_sep;
    assign do_feed   = proc_go && !is_stx && !is_etx && !skip_reg && room && !is_sep;

    assign dec_ctl.clear = (proc_go && is_stx) || do_commit;
    assign dec_ctl.feed  = do_feed;

    fdfp_field_decoder #(
        .VALUE_BITS (VALUE_BITS)
    ) u_field_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dec_ctl),
        .rx_byte (in_byte_reg),
        .value   (cur_value)
    );

    // input register control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_next = 1'b0;
        end
    end

    // frame state update
    always_comb
    begin
        skip_next = skip_reg;
        idx_next  = idx_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            committed_next[i] = committed_reg[i];
        end
        if (proc_go && is_stx)
        begin
            skip_next = 1'b0;
            idx_next  = '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                committed_next[i] = '1;
            end
        end
        else if (proc_go && !is_etx && skip_reg)
        begin
            skip_next = 1'b0;
        end
        else if (do_commit)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (IDX_W'(i) == idx_reg)
                begin
                    committed_next[i] = cur_value;
                end
            end
            idx_next = idx_reg + 1'b1;
        end
    end

    // result assembly
    assign found_full     = room ? ({1'b0, idx_reg} + 1'b1) : {1'b0, IDX_LAST};
    assign out_found_next = FOUND_BITS'(found_full);

    for (genvar g = 0; g < OUT_VALUES; g++)
    begin : g_out_value
        if (g < NUM_FIELDS)
        begin : g_stored
            always_comb
            begin
                if (IDX_W'(g) < idx_reg)
                begin
                    out_value_next[g] = committed_reg[g];
                end
                else if (IDX_W'(g) == idx_reg)
                begin
                    out_value_next[g] = cur_value;
                end
                else
                begin
                    out_value_next[g] = '1;
                end
            end
        end
        else
        begin : g_absent
            assign out_value_next[g] = '1;
        end
        assign payload[g*VALUE_BITS +: VALUE_BITS] = out_value_reg[g];
    end

    assign payload[OUT_W-1 -: FOUND_BITS] = out_found_reg;

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_go && is_etx)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            skip_reg      <= 1'b1;
            idx_reg       <= '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                committed_reg[i] <= '1;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            skip_reg      <= skip_next;
            idx_reg       <= idx_next;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                committed_reg[i] <= committed_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_src_reg  <= s_tuser;
        end
        if (proc_go && is_etx)
        begin
            for (int i = 0; i < OUT_VALUES; i++)
            begin
                out_value_reg[i] <= out_value_next[i];
            end
            out_found_reg <= out_found_next;
            out_src_reg   <= in_src_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(payload);
    assign m_tuser  = out_src_reg;

    // field count never passes the number of stored fields
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("field index beyond field count");

    // a start byte restarts the field count
    a_stx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && is_stx) |=> (idx_reg == '0) && !skip_reg)
        else $error("start byte did not restart frame");

    // an end byte that is taken always lands in the result register
    a_etx_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && is_etx) |=> out_valid_reg)
        else $error("end byte produced no result");

    // a separator that commits a field advances the field count by one
    a_sep_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("separator did not advance field");

    // input side only stalls while a byte is held
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && is_etx && out_valid_reg))
        else $error("input stalled without a held end byte");

endmodule
